FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects a clock named clk
// and an active high reset named rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

FILE: src/bbc_pkg.sv
package bbc_pkg;

  // Default sizes for the top level parameters.
  localparam int STACK_DEPTH_DEF = 256;
  localparam int LINE_BITS_DEF   = 20;

  // Fixed width of the reported line number.
  localparam int LINE_OUT_BITS = 20;

  // Character codes that the checker looks for.
  localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;
  localparam logic [7:0] CHAR_OPEN_ROUND  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE_ROUND = 8'h29;
  localparam logic [7:0] CHAR_OPEN_CURLY  = 8'h7B;
  localparam logic [7:0] CHAR_CLOSE_CURLY = 8'h7D;
  localparam logic [7:0] CHAR_OPEN_SQUARE = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ROUND  = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_SQUARE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BALANCED = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_MISSING  = 3'd3,
    ST_UNCLOSED = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  // Classification of one text byte.
  typedef struct packed {
    logic  newline;
    kind_t opener;
    kind_t closer;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] ch);
    char_class_t c;
    c.newline = 1'b0;
    c.opener  = KIND_NONE;
    c.closer  = KIND_NONE;
    case (ch)
      CHAR_NEWLINE:      c.newline = 1'b1;
      CHAR_OPEN_ROUND:   c.opener  = KIND_ROUND;
      CHAR_OPEN_CURLY:   c.opener  = KIND_CURLY;
      CHAR_OPEN_SQUARE:  c.opener  = KIND_SQUARE;
      CHAR_CLOSE_ROUND:  c.closer  = KIND_ROUND;
      CHAR_CLOSE_CURLY:  c.closer  = KIND_CURLY;
      CHAR_CLOSE_SQUARE: c.closer  = KIND_SQUARE;
      default: ;
    endcase
    return c;
  endfunction

endpackage

FILE: src/bbc_in_if.sv
// Input channel: one text byte or an end-of-file marker per word.
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_marker;

  modport source (output valid, output text_byte, output end_marker, input ready);
  modport sink   (input valid, input text_byte, input end_marker, output ready);
endinterface

FILE: src/bbc_out_if.sv
// Result channel: one check result per word.
interface bbc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [19:0] line_number;
  logic [1:0]  expected_kind;
  logic [1:0]  found_kind;

  modport source (output valid, output status, output line_number,
                  output expected_kind, output found_kind, input ready);
  modport sink   (input valid, input status, input line_number,
                  input expected_kind, input found_kind, output ready);
endinterface

FILE: src/bracket_balance_checker.sv
// Bracket balance checker.
// The text channel carries one word per character: text_byte, or end_marker
// set to close the file. The result channel returns exactly one word for
// every text word, in order. A word is taken whenever the result register is
// empty or is being drained in the same cycle, so one character is checked
// per clock cycle; the result appears in the cycle after its word is taken.
// The open bracket kinds live in a stack RAM. The top of stack is held in a
// register, and the RAM is read every cycle at the entry under the next top,
// so a pop has its new top ready in the following cycle without a stall.
// Openers push, matching closers pop, and the first error (mismatched
// closer, missing opener, stack overflow) freezes the check until the end
// marker, which reports the verdict if no error came first and clears the
// count, the line counter and the error flag. Reset does the same; the RAM
// needs no clearing pass because only entries below the count are ever read.
// When the receiver holds ready low, the result word waits in its register
// and the text channel is stalled until it is taken.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
  parameter int LINE_BITS   = bbc_pkg::LINE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bbc_in_if.sink     text,
  bbc_out_if.source  result
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int LW = LINE_BITS + bbc_pkg::LINE_OUT_BITS;

  logic [CW-1:0]        count, count_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic                 failed, failed_next;
  bbc_pkg::kind_t       top, top_next;

  logic                 accept;
  bbc_pkg::char_class_t cls;
  bbc_pkg::kind_t       top_cur;
  bbc_pkg::kind_t       below;

  logic                 push_we;
  logic [CW-1:0]        raddr_full;
  logic [AW-1:0]        raddr;
  logic [1:0]           rdata;

  bbc_pkg::status_t     st_emit;
  bbc_pkg::kind_t       exp_emit;
  bbc_pkg::kind_t       found_emit;
  logic [LINE_BITS-1:0] line_emit;
  logic [LW-1:0]        line_ext;

  // The result register frees up when empty or drained this cycle.
  assign text.ready = !result.valid || result.ready;
  assign accept     = text.valid && text.ready;

  assign cls     = bbc_pkg::classify(text.text_byte);
  assign top_cur = (count == '0) ? bbc_pkg::KIND_NONE : top;
  assign below   = bbc_pkg::kind_t'(rdata);

  // Next state and the result word for the accepted text word.
  always_comb begin
    count_next = count;
    line_next  = line;
    failed_next = failed;
    top_next   = top;
    push_we    = 1'b0;
    st_emit    = bbc_pkg::ST_OK;
    exp_emit   = bbc_pkg::KIND_NONE;
    found_emit = bbc_pkg::KIND_NONE;
    if (accept) begin
      if (text.end_marker) begin
        if (!failed) begin
          if (count == '0) begin
            st_emit = bbc_pkg::ST_BALANCED;
          end else begin
            st_emit  = bbc_pkg::ST_UNCLOSED;
            exp_emit = top_cur;
          end
        end
        count_next  = '0;
        line_next   = LINE_BITS'(1);
        failed_next = 1'b0;
      end else if (!failed) begin
        if (cls.newline && (line != '1)) begin
          line_next = line + LINE_BITS'(1);
        end
        if (cls.opener != bbc_pkg::KIND_NONE) begin
          if (count == CW'(STACK_DEPTH)) begin
            failed_next = 1'b1;
            st_emit     = bbc_pkg::ST_OVERFLOW;
            exp_emit    = top_cur;
          end else begin
            push_we    = 1'b1;
            count_next = count + CW'(1);
            top_next   = cls.opener;
            exp_emit   = cls.opener;
          end
        end else if (cls.closer != bbc_pkg::KIND_NONE) begin
          found_emit = cls.closer;
          if (count == '0) begin
            failed_next = 1'b1;
            st_emit     = bbc_pkg::ST_MISSING;
          end else if (top_cur != cls.closer) begin
            failed_next = 1'b1;
            st_emit     = bbc_pkg::ST_MISMATCH;
            exp_emit    = top_cur;
          end else begin
            count_next = count - CW'(1);
            top_next   = below;
            exp_emit   = (count == CW'(1)) ? bbc_pkg::KIND_NONE : below;
          end
        end else begin
          exp_emit = top_cur;
        end
      end
    end
  end

  // The end marker reports the line before the counter is cleared.
  assign line_emit = (accept && text.end_marker) ? line : line_next;
  assign line_ext  = LW'(line_emit);

  // Read the entry under the next top so a pop finds it in the following cycle.
  assign raddr_full = count_next - CW'(2);
  assign raddr      = raddr_full[AW-1:0];

  bbc_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push_we),
    .waddr (count[AW-1:0]),
    .wdata (cls.opener),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Checker state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      line   <= LINE_BITS'(1);
      failed <= 1'b0;
    end else begin
      count  <= count_next;
      line   <= line_next;
      failed <= failed_next;
    end
  end

  // The cached top needs no reset: it is only used while the count is nonzero.
  always_ff @(posedge clk) begin
    top <= top_next;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.status        <= st_emit;
      result.line_number   <= line_ext[bbc_pkg::LINE_OUT_BITS-1:0];
      result.expected_kind <= exp_emit;
      result.found_kind    <= found_emit;
    end
  end

  // The stack count never passes the depth.
  `ASSERT_ALWAYS(a_count_range, count <= CW'(STACK_DEPTH), "stack count beyond depth")

  // An end marker returns the checker to its reset state.
  `ASSERT_NEXT(a_end_clears, accept && text.end_marker,
               count == '0 && !failed && line == LINE_BITS'(1), "end marker did not clear")

  // Once failed, nothing but an end marker clears the error.
  `ASSERT_NEXT(a_failed_sticky, failed && !(accept && text.end_marker),
               failed && $stable(count) && $stable(line), "frozen state changed")

  // A stalled result word is never overwritten.
  `ASSERT_NEXT(a_no_overwrite, result.valid && !result.ready,
               result.valid && $stable(result.status) && $stable(result.line_number),
               "result word lost while stalled")

endmodule

FILE: src/bbc_ram.sv
// Simple dual port RAM: one write port, one read port with registered data.
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam logic [LINE_OUT_BITS-1:0] LINE_TOP = {LINE_OUT_BITS{1'b1}};
  localparam int unsigned RANDOM_WORDS = 1600;
  localparam longint unsigned CYCLE_LIMIT = 500_000;
  localparam int NROWS = 28;

  typedef struct {
    status_t                  status;
    logic [LINE_OUT_BITS-1:0] line_number;
    kind_t                    expected_kind;
    kind_t                    found_kind;
  } verdict_t;

  typedef struct {
    logic [7:0]  text_byte;
    logic        end_marker;
    int unsigned reps;
    bit          typed;
    verdict_t    want;
  } plan_row_t;

  logic clk;
  logic rst;
  bit   rst_done;
  bit   steady;

  bbc_in_if  in_ch();
  bbc_out_if out_ch();

  bracket_balance_checker dut (
    .clk    (clk),
    .rst    (rst),
    .text   (in_ch),
    .result (out_ch)
  );

  // Mirror of the checker: open kinds, line counter and frozen flag.
  kind_t                    open_kinds [DEPTH];
  int unsigned              open_depth;
  logic [LINE_OUT_BITS-1:0] cur_line;
  bit                       frozen;

  verdict_t    pending_verdicts [$];
  int unsigned failures;
  int unsigned words_sent;
  int unsigned files_sent;
  int unsigned words_checked;
  int unsigned verdict_seen [6];
  longint unsigned cycles;

  plan_row_t plan [NROWS];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_tracker();
    open_depth = 0;
    cur_line   = 1;
    frozen     = 1'b0;
  endfunction

  function automatic kind_t top_kind();
    if (open_depth == 0) return KIND_NONE;
    return open_kinds[open_depth-1];
  endfunction

  // Expected result for one accepted text word; updates the mirror state.
  function automatic verdict_t predict_verdict(logic [7:0] b, logic eom);
    verdict_t r;
    kind_t    op;
    kind_t    cl;
    r.status        = ST_OK;
    r.line_number   = cur_line;
    r.expected_kind = KIND_NONE;
    r.found_kind    = KIND_NONE;
    if (eom) begin
      if (!frozen) begin
        if (open_depth == 0) begin
          r.status = ST_BALANCED;
        end else begin
          r.status        = ST_UNCLOSED;
          r.expected_kind = top_kind();
        end
      end
      clear_tracker();
      return r;
    end
    if (frozen) return r;
    op = KIND_NONE;
    cl = KIND_NONE;
    case (b)
      CHAR_NEWLINE: begin
        if (cur_line != LINE_TOP) cur_line = cur_line + 1'b1;
      end
      CHAR_OPEN_ROUND:   op = KIND_ROUND;
      CHAR_OPEN_CURLY:   op = KIND_CURLY;
      CHAR_OPEN_SQUARE:  op = KIND_SQUARE;
      CHAR_CLOSE_ROUND:  cl = KIND_ROUND;
      CHAR_CLOSE_CURLY:  cl = KIND_CURLY;
      CHAR_CLOSE_SQUARE: cl = KIND_SQUARE;
      default: ;
    endcase
    r.line_number = cur_line;
    if (op != KIND_NONE) begin
      if (open_depth >= DEPTH) begin
        frozen          = 1'b1;
        r.status        = ST_OVERFLOW;
        r.expected_kind = top_kind();
        return r;
      end
      open_kinds[open_depth] = op;
      open_depth++;
    end else if (cl != KIND_NONE) begin
      if (open_depth == 0) begin
        frozen       = 1'b1;
        r.status     = ST_MISSING;
        r.found_kind = cl;
        return r;
      end
      if (top_kind() != cl) begin
        frozen          = 1'b1;
        r.status        = ST_MISMATCH;
        r.expected_kind = top_kind();
        r.found_kind    = cl;
        return r;
      end
      open_depth--;
    end
    r.expected_kind = top_kind();
    r.found_kind    = cl;
    return r;
  endfunction

  function automatic logic [7:0] opener_char(kind_t k);
    case (k)
      KIND_ROUND: return CHAR_OPEN_ROUND;
      KIND_CURLY: return CHAR_OPEN_CURLY;
      default:    return CHAR_OPEN_SQUARE;
    endcase
  endfunction

  function automatic logic [7:0] closer_char(kind_t k);
    case (k)
      KIND_ROUND: return CHAR_CLOSE_ROUND;
      KIND_CURLY: return CHAR_CLOSE_CURLY;
      default:    return CHAR_CLOSE_SQUARE;
    endcase
  endfunction

  // Any byte that is not a bracket; newlines are allowed.
  function automatic logic [7:0] filler_char();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b inside {CHAR_OPEN_ROUND, CHAR_CLOSE_ROUND, CHAR_OPEN_CURLY,
                         CHAR_CLOSE_CURLY, CHAR_OPEN_SQUARE, CHAR_CLOSE_SQUARE});
    return b;
  endfunction

  // Drive one text word, after a random gap unless steady, and record its expected result.
  task automatic send_word(logic [7:0] b, logic eom, bit typed, verdict_t want);
    int unsigned gap;
    verdict_t    v;
    gap = steady ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.text_byte  <= b;
    in_ch.end_marker <= eom;
    do @(posedge clk); while (!in_ch.ready);
    v = predict_verdict(b, eom);
    pending_verdicts.push_back(typed ? want : v);
    words_sent++;
    if (eom) files_sent++;
  endtask

  task automatic send_plain(logic [7:0] b, logic eom);
    verdict_t none;
    none = '{ST_OK, '0, KIND_NONE, KIND_NONE};
    send_word(b, eom, 1'b0, none);
  endtask

  // The sender goes idle until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // One random file: mostly well nested with random content, some broken.
  task automatic send_random_file();
    kind_t       stack_q [$];
    int unsigned mode;
    int unsigned n;
    int unsigned pick;
    int unsigned i;
    kind_t       k;
    mode   = $urandom_range(0, 19);
    steady = ($urandom_range(0, 4) == 0);
    n      = $urandom_range(1, 40);
    if (mode == 19) begin
      // Deep nesting around the stack capacity.
      n = $urandom_range(DEPTH - 6, DEPTH + 4);
      for (i = 0; i < n; i++) begin
        k = kind_t'($urandom_range(1, 3));
        stack_q.push_back(k);
        send_plain(opener_char(k), 1'b0);
      end
    end else begin
      for (i = 0; i < n; i++) begin
        pick = $urandom_range(0, 9);
        if (mode == 18) begin
          send_plain(8'($urandom_range(0, 255)), 1'b0);
        end else if (i == n / 2 && (mode == 14 || mode == 15) && stack_q.size() != 0) begin
          // Wrong closer for the current top.
          k = kind_t'((int'(stack_q[$]) % 3) + 1);
          send_plain(closer_char(k), 1'b0);
        end else if (i == n / 2 && (mode == 16 || mode == 17)) begin
          // Close everything, then one closer too many.
          while (stack_q.size() != 0) send_plain(closer_char(stack_q.pop_back()), 1'b0);
          send_plain(closer_char(kind_t'($urandom_range(1, 3))), 1'b0);
        end else if (pick <= 2) begin
          k = kind_t'($urandom_range(1, 3));
          stack_q.push_back(k);
          send_plain(opener_char(k), 1'b0);
        end else if (pick <= 5 && stack_q.size() != 0) begin
          send_plain(closer_char(stack_q.pop_back()), 1'b0);
        end else if (pick == 6) begin
          send_plain(CHAR_NEWLINE, 1'b0);
        end else begin
          send_plain(filler_char(), 1'b0);
        end
      end
    end
    // Unclosed files stop short; the rest close what is open.
    if (mode != 12 && mode != 13) begin
      while (stack_q.size() != 0) send_plain(closer_char(stack_q.pop_back()), 1'b0);
    end
    send_plain(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Result side: random stalls, then compare each word with the oldest expectation.
  initial begin : drain_results
    int unsigned gap;
    verdict_t    w;
    out_ch.ready = 1'b0;
    wait (rst_done);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_verdicts.size() == 0) begin
        $error("result word with no expectation pending: status %0d line %0d",
               out_ch.status, out_ch.line_number);
        failures++;
      end else begin
        w = pending_verdicts.pop_front();
        words_checked++;
        if (int'(w.status) < 6) verdict_seen[int'(w.status)]++;
        if (out_ch.status !== w.status) begin
          $error("status: expected %0d, actual %0d", w.status, out_ch.status);
          failures++;
        end
        if (out_ch.line_number !== w.line_number) begin
          $error("line_number: expected %0d, actual %0d", w.line_number,
                 out_ch.line_number);
          failures++;
        end
        if (out_ch.expected_kind !== w.expected_kind) begin
          $error("expected_kind: expected %0d, actual %0d", w.expected_kind,
                 out_ch.expected_kind);
          failures++;
        end
        if (out_ch.found_kind !== w.found_kind) begin
          $error("found_kind: expected %0d, actual %0d", w.found_kind,
                 out_ch.found_kind);
          failures++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus: directed plan, then random files.
  initial begin : stimulus
    int unsigned r;
    int unsigned rep;
    int unsigned rand_start;
    in_ch.valid      = 1'b0;
    in_ch.text_byte  = '0;
    in_ch.end_marker = 1'b0;
    rst              = 1'b1;
    steady           = 1'b0;
    failures         = 0;
    clear_tracker();

    plan = '{
      '{8'h61, 1'b0, 1, 1'b1, '{ST_OK, 20'd1, KIND_NONE, KIND_NONE}},
      // Closer on an empty stack, then frozen until end of file.
      '{CHAR_CLOSE_ROUND, 1'b0, 1, 1'b1, '{ST_MISSING, 20'd1, KIND_NONE, KIND_ROUND}},
      '{CHAR_OPEN_ROUND, 1'b0, 1, 1'b1, '{ST_OK, 20'd1, KIND_NONE, KIND_NONE}},
      '{8'h00, 1'b1, 1, 1'b1, '{ST_OK, 20'd1, KIND_NONE, KIND_NONE}},
      '{8'h00, 1'b1, 1, 1'b1, '{ST_BALANCED, 20'd1, KIND_NONE, KIND_NONE}},
      // Nest across a newline, with a wrong closer for the outer round bracket.
      '{CHAR_OPEN_ROUND, 1'b0, 1, 1'b0, '{ST_OK, '0, KIND_NONE, KIND_NONE}},
      '{CHAR_OPEN_CURLY, 1'b0, 1, 1'b0, '{ST_OK, '0, KIND_NONE, KIND_NONE}},
      '{CHAR_OPEN_SQUARE, 1'b0, 1, 1'b0, '{ST_OK, '0, KIND_NONE, KIND_NONE}},
      '{CHAR_NEWLINE, 1'b0, 1, 1'b0, '{ST_OK, '0, KIND_NONE, KIND_NONE}},
      '{CHAR_CLOSE_SQUARE, 1'b0, 1, 1'b0, '{ST_OK, '0, KIND_NONE, KIND_NONE}},
      '{CHAR_CLOSE_CURLY, 1'b0, 1, 1'b0, '{ST_OK, '0, KIND_NONE, KIND_NONE}},
      '{CHAR_CLOSE_SQUARE, 1'b0, 1, 1'b1, '{ST_MISMATCH, 20'd2, KIND_ROUND, KIND_SQUARE}},
      // A frozen newline leaves the line count alone.
      '{CHAR_NEWLINE, 1'b0, 1, 1'b1, '{ST_OK, 20'd2, KIND_NONE, KIND_NONE}},
      '{8'h00, 1'b1, 1, 1'b1, '{ST_OK, 20'd2, KIND_NONE, KIND_NONE}},
      '{CHAR_OPEN_SQUARE, 1'b0, 1, 1'b1, '{ST_OK, 20'd1, KIND_SQUARE, KIND_NONE}},
      '{CHAR_CLOSE_ROUND, 1'b0, 1, 1'b1, '{ST_MISMATCH, 20'd1, KIND_SQUARE, KIND_ROUND}},
      '{8'hFF, 1'b1, 1, 1'b1, '{ST_OK, 20'd1, KIND_NONE, KIND_NONE}},
      // Unclosed at end of file.
      '{CHAR_OPEN_CURLY, 1'b0, 1, 1'b1, '{ST_OK, 20'd1, KIND_CURLY, KIND_NONE}},
      '{8'h00, 1'b1, 1, 1'b1, '{ST_UNCLOSED, 20'd1, KIND_CURLY, KIND_NONE}},
      '{8'hFF, 1'b0, 1, 1'b1, '{ST_OK, 20'd1, KIND_NONE, KIND_NONE}},
      '{8'h00, 1'b0, 1, 1'b1, '{ST_OK, 20'd1, KIND_NONE, KIND_NONE}},
      // The byte that rides along with the end marker is ignored.
      '{CHAR_OPEN_ROUND, 1'b1, 1, 1'b1, '{ST_BALANCED, 20'd1, KIND_NONE, KIND_NONE}},
      // Fill the stack, then one push too many.
      '{CHAR_OPEN_ROUND, 1'b0, DEPTH, 1'b0, '{ST_OK, '0, KIND_NONE, KIND_NONE}},
      '{CHAR_OPEN_CURLY, 1'b0, 1, 1'b1, '{ST_OVERFLOW, 20'd1, KIND_ROUND, KIND_NONE}},
      '{8'h00, 1'b1, 1, 1'b1, '{ST_OK, 20'd1, KIND_NONE, KIND_NONE}},
      // Count lines across a long run of newlines.
      '{CHAR_NEWLINE, 1'b0, 98, 1'b0, '{ST_OK, '0, KIND_NONE, KIND_NONE}},
      '{CHAR_NEWLINE, 1'b0, 1, 1'b1, '{ST_OK, 20'd100, KIND_NONE, KIND_NONE}},
      '{8'h00, 1'b1, 1, 1'b1, '{ST_BALANCED, 20'd100, KIND_NONE, KIND_NONE}}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    rst_done = 1'b1;

    // Directed plan; runs of over 1000 words would go without idling on either side.
    for (r = 0; r < NROWS; r++) begin
      steady = (plan[r].reps > 1000);
      for (rep = 0; rep < plan[r].reps; rep++) begin
        send_word(plan[r].text_byte, plan[r].end_marker, plan[r].typed, plan[r].want);
      end
    end
    steady = 1'b0;
    wait_drained();

    // Random files, with an occasional full drain before the next file.
    rand_start = words_sent;
    while (words_sent - rand_start < RANDOM_WORDS) begin
      send_random_file();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
    steady = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Ran %0d text words in %0d files, %0d results compared in %0d cycles.",
             words_sent, files_sent, words_checked, cycles);
    $display("Verdicts: balanced %0d, unclosed %0d, mismatch %0d, missing %0d, overflow %0d.",
             verdict_seen[int'(ST_BALANCED)], verdict_seen[int'(ST_UNCLOSED)],
             verdict_seen[int'(ST_MISMATCH)], verdict_seen[int'(ST_MISSING)],
             verdict_seen[int'(ST_OVERFLOW)]);
    if (failures == 0 && pending_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/bbc_pkg.sv
src/bbc_in_if.sv
src/bbc_out_if.sv
src/bbc_ram.sv
src/bracket_balance_checker.sv
tb/tb.sv
